// ===== sv/gf2alu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2alu_pkg
// Shared operation codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package gf2alu_pkg;

	localparam int PORT_W = 64;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_ADD = 2'd0;
	localparam kind_t KIND_MUL = 2'd1;
	localparam kind_t KIND_REM = 2'd2;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic mul_step;
		logic norm_step;
		logic red_step;
		logic commit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		kind_t in_kind;
		logic  in_b_zero;
		logic  b_top;
		logic  cnt_zero;
	} sts_t;

endpackage

// ===== sv/gf2alu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2alu_dp
// Operand registers, shift-and-xor step unit and result register.
// ----------------------------------------------------------------------------
module gf2alu_dp #(
	parameter int POLY_WIDTH = 64
) (
	input  logic                  clk,
	input  gf2alu_pkg::kind_t     kind,
	input  logic [POLY_WIDTH-1:0] operand_a,
	input  logic [POLY_WIDTH-1:0] operand_b,
	input  gf2alu_pkg::cmd_t      cmd,
	output gf2alu_pkg::sts_t      sts,
	output logic [POLY_WIDTH-1:0] result,
	output logic                  divide_error
);
	import gf2alu_pkg::*;

	localparam int W  = POLY_WIDTH;
	localparam int CW = $clog2(W);

	logic [W-1:0]  a_q, b_q, acc_q, mark_q, res_q;
	logic [CW-1:0] cnt_q;
	kind_t         kind_q;
	logic          err_q, res_err_q;
	logic          in_b_zero;

	assign in_b_zero = (operand_b == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			a_q    <= operand_a;
			b_q    <= operand_b;
			mark_q <= {1'b1, {(W-1){1'b0}}};
			err_q  <= (kind == KIND_REM) && in_b_zero;
			if (kind == KIND_MUL) begin
				cnt_q <= CW'(W-1);
			end else begin
				cnt_q <= '0;
			end
			unique case (kind)
				KIND_ADD: acc_q <= operand_a ^ operand_b;
				default:  acc_q <= '0;
			endcase
		end else if (cmd.mul_step) begin
			if (a_q[0]) begin
				acc_q <= acc_q ^ b_q;
			end
			a_q   <= a_q >> 1;
			b_q   <= b_q << 1;
			cnt_q <= cnt_q - 1'b1;
		end else if (cmd.norm_step) begin
			// align divisor's leading term with the top bit
			b_q   <= b_q << 1;
			cnt_q <= cnt_q + 1'b1;
		end else if (cmd.red_step) begin
			if ((a_q & mark_q) != '0) begin
				a_q <= a_q ^ b_q;
			end
			b_q    <= b_q >> 1;
			mark_q <= mark_q >> 1;
			cnt_q  <= cnt_q - 1'b1;
		end
		if (cmd.commit) begin
			res_q     <= (kind_q == KIND_REM) ? a_q : acc_q;
			res_err_q <= err_q;
		end
	end

	assign sts.in_kind   = kind;
	assign sts.in_b_zero = in_b_zero;
	assign sts.b_top     = b_q[W-1];
	assign sts.cnt_zero  = (cnt_q == '0);

	assign result       = res_q;
	assign divide_error = res_err_q;

endmodule

// ===== sv/gf2alu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2alu_ctrl
// Sequencer: accepts a request, steps the datapath, loads the output slot.
// ----------------------------------------------------------------------------
module gf2alu_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  gf2alu_pkg::sts_t sts,
	output gf2alu_pkg::cmd_t cmd
);
	import gf2alu_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_NORM = 3'd2;
	localparam logic [2:0] ST_RED  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					priority if (sts.in_kind == KIND_MUL) begin
						state_d = ST_MUL;
					end else if (sts.in_kind == KIND_REM && !sts.in_b_zero) begin
						state_d = ST_NORM;
					end else begin
						state_d = ST_FIN;
					end
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (sts.cnt_zero) begin
					state_d = ST_FIN;
				end
			end
			ST_NORM: begin
				if (sts.b_top) begin
					state_d = ST_RED;
				end else begin
					cmd.norm_step = 1'b1;
				end
			end
			ST_RED: begin
				cmd.red_step = 1'b1;
				if (sts.cnt_zero) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/gf2_polynomial_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_polynomial_alu
// Add, carry-less multiply and remainder on polynomials over GF(2).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: kind, operand_a,
//   operand_b. Only the low POLY_WIDTH bits of each operand are used.
//   Output channel (out_valid/out_ready) returns one result per request:
//   result (zero above POLY_WIDTH) and divide_error.
//   One request is worked on at a time; in_ready is high only when the
//   sequencer is idle.
//   Work between acceptance and out_valid:
//     add, unused kind, zero divisor : none; the result is loaded directly
//     multiply                       : one operand bit a step
//     remainder                      : the
//       divisor is first shifted up to its leading term (one bit a cycle),
//       then reduced one degree a cycle through the single shift-xor unit.
//   in_ready returns with out_valid, so a new request is accepted only
//   once the previous one has been loaded into the output register.
//   The output register holds a finished result while the next request is
//   accepted and computed; a sequencer that finishes while that register is
//   still full waits until the receiver takes it.
//   Reset (arst_n low) returns the sequencer to idle and empties the output
//   register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module gf2_polynomial_alu #(
	parameter int POLY_WIDTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  gf2alu_pkg::kind_t                    kind,
	input  logic [gf2alu_pkg::PORT_W-1:0]        operand_a,
	input  logic [gf2alu_pkg::PORT_W-1:0]        operand_b,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [gf2alu_pkg::PORT_W-1:0]        result,
	output logic                                 divide_error
);
	import gf2alu_pkg::*;

	cmd_t                  cmd;
	sts_t                  sts;
	logic [POLY_WIDTH-1:0] dp_result;

	// sequencer: one request at a time, holds until the output slot frees
	gf2alu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: drop operand bits above POLY_WIDTH on the way in
	gf2alu_dp #(
		.POLY_WIDTH (POLY_WIDTH)
	) u_dp (
		.clk          (clk),
		.kind         (kind),
		.operand_a    (operand_a[POLY_WIDTH-1:0]),
		.operand_b    (operand_b[POLY_WIDTH-1:0]),
		.cmd          (cmd),
		.sts          (sts),
		.result       (dp_result),
		.divide_error (divide_error)
	);

	// zero-extend the result to the port width
	assign result = PORT_W'(dp_result);

endmodule

// ===== sv/gf2alu_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2alu_chk
// Port-level checks on request sequencing and output holding.
// ----------------------------------------------------------------------------
module gf2alu_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [gf2alu_pkg::PORT_W-1:0] result,
	input logic                          divide_error
);
	import gf2alu_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result) && $stable(divide_error))
		else $error("result changed while stalled");

	// one request at a time: no back-to-back acceptance
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request accepted while busy");

	// a new result is loaded only while the sequencer is busy
	a_load_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared with no request in flight");

	// a result never appears in the cycle after a request is taken
	a_no_zero_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared one cycle after acceptance");

endmodule

bind gf2_polynomial_alu gf2alu_chk u_chk (.*);
